@@ rtl/int_to_decimal_ascii_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the integer-to-decimal block
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_ASCII_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication
`define ITDA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itda assertion failed");

// Next-cycle implication
`define ITDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itda assertion failed");

`endif

@@ rtl/itda_pkg.sv @@
// ----------------------------------------------------------------------------
// itda_pkg
// Shared constants and the BCD digit correction for the decimal converter.
// ----------------------------------------------------------------------------
package itda_pkg;

    localparam int unsigned DIGIT_W = 4;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    // Decimal digit correction before each doubling
    localparam logic [DIGIT_W-1:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD   = 4'd3;

    typedef logic [DIGIT_W-1:0] digit_t;

    function automatic digit_t bcd_adjust(input digit_t d);
        if (d >= BCD_ADJ_LIMIT)
        begin
            return d + BCD_ADJ_ADD;
        end
        return d;
    endfunction

endpackage

@@ rtl/itda_dabble_stage.sv @@
// ----------------------------------------------------------------------------
// itda_dabble_stage
// One register stage of the binary-to-BCD pipeline: STEPS shift-and-correct
// steps of double dabble, with a valid bit and stall back-pressure.
// ----------------------------------------------------------------------------
module itda_dabble_stage #(
    parameter int DATA_WIDTH = 32,
    parameter int NUM_DIGITS = 10,
    parameter int STEPS      = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [DATA_WIDTH-1:0]                  in_bin,
    input  logic [NUM_DIGITS*itda_pkg::DIGIT_W-1:0] in_bcd,
    input  logic                                   in_neg,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [DATA_WIDTH-1:0]                  out_bin,
    output logic [NUM_DIGITS*itda_pkg::DIGIT_W-1:0] out_bcd,
    output logic                                   out_neg
);

    localparam int BCD_W = NUM_DIGITS * itda_pkg::DIGIT_W;

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] bin_reg;
    logic [BCD_W-1:0]      bcd_reg;
    logic                  neg_reg;

    logic [DATA_WIDTH-1:0] bin_next;
    logic [BCD_W-1:0]      bcd_next;

    always_comb
    begin
        bin_next = in_bin;
        bcd_next = in_bcd;
        for (int st = 0; st < STEPS; st++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                bcd_next[d*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W] =
                    itda_pkg::bcd_adjust(bcd_next[d*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W]);
            end
            bcd_next = {bcd_next[BCD_W-2:0], bin_next[DATA_WIDTH-1]};
            bin_next = {bin_next[DATA_WIDTH-2:0], 1'b0};
        end
    end

    // Hold while the stage is full and downstream stalls
    assign in_stall = valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
            neg_reg <= in_neg;
        end
    end

    assign out_valid = valid_reg;
    assign out_bin   = bin_reg;
    assign out_bcd   = bcd_reg;
    assign out_neg   = neg_reg;

endmodule

@@ rtl/itda_emit.sv @@
// ----------------------------------------------------------------------------
// itda_emit
// Character serializer: takes one BCD number, skips leading zeros and sends
// an optional minus sign and then the digits, one per transaction.
// ----------------------------------------------------------------------------
module itda_emit #(
    parameter int NUM_DIGITS = 10
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [NUM_DIGITS*itda_pkg::DIGIT_W-1:0] in_bcd,
    input  logic                                   in_neg,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [7:0]                             text_char,
    output logic                                   last_char
);

    localparam int BCD_W = NUM_DIGITS * itda_pkg::DIGIT_W;
    localparam int IDX_W = $clog2(NUM_DIGITS);

    logic                  busy_reg,      busy_next;
    logic                  minus_reg,     minus_next;
    logic [IDX_W-1:0]      idx_reg,       idx_next;
    logic [BCD_W-1:0]      digits_reg,    digits_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            char_reg,      char_next;
    logic                  last_reg,      last_next;

    logic                  advance;
    logic                  finishing;
    logic                  load;
    logic [IDX_W-1:0]      msd;
    itda_pkg::digit_t      cur_digit;

    // Index of the most significant nonzero digit; zero gives index 0
    always_comb
    begin
        msd = '0;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (in_bcd[d*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W] != '0)
            begin
                msd = IDX_W'(d);
            end
        end
    end

    assign cur_digit = digits_reg[idx_reg*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W];
    assign advance   = !out_valid_reg || !out_stall;
    assign finishing = busy_reg && !minus_reg && (idx_reg == '0);
    assign in_stall  = busy_reg && !(advance && finishing);
    assign load      = in_valid && !in_stall;

    always_comb
    begin
        busy_next      = busy_reg;
        minus_next     = minus_reg;
        idx_next       = idx_reg;
        digits_next    = digits_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;

        if (advance)
        begin
            out_valid_next = busy_reg;
            if (busy_reg)
            begin
                if (minus_reg)
                begin
                    char_next  = itda_pkg::CHAR_MINUS;
                    last_next  = 1'b0;
                    minus_next = 1'b0;
                end
                else
                begin
                    char_next = itda_pkg::CHAR_ZERO + {4'b0000, cur_digit};
                    last_next = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
        end

        // Take the next number when idle or as the current one finishes
        if (load)
        begin
            busy_next   = 1'b1;
            minus_next  = in_neg;
            idx_next    = msd;
            digits_next = in_bcd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            minus_reg     <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            minus_reg     <= minus_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign text_char = char_reg;
    assign last_char = last_reg;

endmodule

@@ rtl/int_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Signed integer to decimal ASCII text, one character per output transaction.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with the signed value on number. Output
// channel: out_valid / out_stall with text_char and last_char. A transaction
// completes on a clock edge with valid high and stall low.
// Each number produces its text most significant character first: '-' for a
// negative value, then the digits with no leading zeros; zero gives "0". The
// final character of a number has last_char set. No terminator is sent.
// The first character appears once the number has passed the sign/magnitude
// register, the double-dabble stages and the serializer. A number takes as
// many output transactions as its text has characters (1 to 11 at 32 bits);
// the output port limits the rate, while the sign/magnitude register and the
// double-dabble stages (up to four bits each) take a number every cycle unless stalled.
// A stall on the output holds the current character and backs up the
// pipeline stage by stage; nothing is dropped or repeated.
// Reset clears all valid bits and the serializer; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "int_to_decimal_ascii_macros.svh"

module int_to_decimal_ascii #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] number,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   text_char,
    output logic                         last_char
);

    localparam int NUM_DIGITS      = (DATA_WIDTH * 301) / 1000 + 1;
    localparam int BCD_W           = NUM_DIGITS * itda_pkg::DIGIT_W;
    localparam int STEPS_PER_STAGE = 4;
    localparam int NUM_STAGES      = (DATA_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    logic                  stg_valid [0:NUM_STAGES];
    logic                  stg_stall [0:NUM_STAGES];
    logic [DATA_WIDTH-1:0] stg_bin   [0:NUM_STAGES];
    logic [BCD_W-1:0]      stg_bcd   [0:NUM_STAGES];
    logic                  stg_neg   [0:NUM_STAGES];

    logic                  front_valid_reg;
    logic [DATA_WIDTH-1:0] mag_reg;
    logic                  neg_reg;
    logic [DATA_WIDTH-1:0] num_u;
    logic                  num_neg;
    logic [DATA_WIDTH-1:0] mag_next;

    // Sign and unsigned magnitude; the most negative value maps to 2^(W-1)
    assign num_u    = number;
    assign num_neg  = num_u[DATA_WIDTH-1];
    assign mag_next = num_neg ? (~num_u) + DATA_WIDTH'(1) : num_u;

    assign in_stall = front_valid_reg && stg_stall[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            mag_reg <= mag_next;
            neg_reg <= num_neg;
        end
    end

    assign stg_valid[0] = front_valid_reg;
    assign stg_bin[0]   = mag_reg;
    assign stg_bcd[0]   = '0;
    assign stg_neg[0]   = neg_reg;

    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_dabble
        localparam int REMAIN = DATA_WIDTH - s * STEPS_PER_STAGE;
        localparam int STEPS  = (REMAIN < STEPS_PER_STAGE) ? REMAIN : STEPS_PER_STAGE;

        itda_dabble_stage #(
            .DATA_WIDTH (DATA_WIDTH),
            .NUM_DIGITS (NUM_DIGITS),
            .STEPS      (STEPS)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[s]),
            .in_stall  (stg_stall[s]),
            .in_bin    (stg_bin[s]),
            .in_bcd    (stg_bcd[s]),
            .in_neg    (stg_neg[s]),
            .out_valid (stg_valid[s+1]),
            .out_stall (stg_stall[s+1]),
            .out_bin   (stg_bin[s+1]),
            .out_bcd   (stg_bcd[s+1]),
            .out_neg   (stg_neg[s+1])
        );
    end

    itda_emit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[NUM_STAGES]),
        .in_stall  (stg_stall[NUM_STAGES]),
        .in_bcd    (stg_bcd[NUM_STAGES]),
        .in_neg    (stg_neg[NUM_STAGES]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .text_char (text_char),
        .last_char (last_char)
    );

    `ITDA_ASSERT_NEXT(a_accept_fills_front, in_valid && !in_stall, front_valid_reg)
    `ITDA_ASSERT_IMPL(a_minus_not_last, out_valid && text_char == itda_pkg::CHAR_MINUS, !last_char)
    `ITDA_ASSERT_IMPL(a_char_is_digit, out_valid && text_char != itda_pkg::CHAR_MINUS, text_char >= itda_pkg::CHAR_ZERO && text_char <= itda_pkg::CHAR_NINE)

endmodule

@@ tb/int_to_decimal_ascii_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_checker
// Watches both channels of the decimal converter. Each number taken on the
// input is turned into its expected decimal text. Each character on the
// output is compared in order against that text.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_checker #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] number,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [7:0]                   text_char,
    input  logic                         last_char,
    output int                           fail_count,
    output int                           pending,
    output int                           chars_checked
);

    localparam int unsigned RADIX     = 10;
    localparam int          MAX_CHARS = 20;
    localparam int          MAX_SHOWN = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } ascii_item_t;

    ascii_item_t expected_chars[$];
    int          mismatches;
    int          checked;

    // Append the decimal text of one number to the expected characters
    function automatic void push_decimal_text(input logic [DATA_WIDTH-1:0] value);
        logic                  neg;
        logic [DATA_WIDTH-1:0] abs_val;
        logic [63:0]           mag;
        logic [3:0]            digit [MAX_CHARS];
        int                    nd;
        ascii_item_t           item;
        neg = value[DATA_WIDTH-1];
        // the most negative value stays as its own unsigned magnitude
        abs_val = neg ? -value : value;
        mag = 64'(abs_val);
        nd = 0;
        do
        begin
            digit[nd] = 4'(mag % RADIX);
            nd++;
            mag = mag / RADIX;
        end
        while (mag != 0 && nd < MAX_CHARS);
        if (neg)
        begin
            item.ch = itda_pkg::CHAR_MINUS;
            item.last = 1'b0;
            expected_chars.push_back(item);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            item.ch = itda_pkg::CHAR_ZERO + 8'(digit[i]);
            item.last = (i == 0);
            expected_chars.push_back(item);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ascii_item_t want;
        if (!rst_n)
        begin
            expected_chars.delete();
            mismatches = 0;
            checked = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                push_decimal_text(number);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                    begin
                        $display("%0t: unexpected character %0d (last %0b), nothing pending",
                                 $realtime, text_char, last_char);
                    end
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (text_char !== want.ch || last_char !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                        begin
                            $display("%0t: character %0d: expected %0d last %0b, got %0d last %0b",
                                     $realtime, checked, want.ch, want.last,
                                     text_char, last_char);
                        end
                    end
                end
                checked++;
            end
        end
        // publish with nonblocking updates so readers see pre-edge values
        fail_count    <= mismatches;
        pending       <= expected_chars.size();
        chars_checked <= checked;
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for int_to_decimal_ascii. Sends edge-case numbers, then mixed
// random ones, with random gaps on the input and random stalls on the output.
// A checker beside the block predicts the text and compares every character.
// ----------------------------------------------------------------------------
module tb;

    localparam int DATA_WIDTH   = 32;
    localparam int LATENCY      = (DATA_WIDTH + 3) / 4 + 2;
    localparam int RANDOM_ITEMS = 350;
    localparam int NUM_EDGES    = 22;

    localparam logic [31:0] EDGE_NUMBERS [NUM_EDGES] = '{
        32'd0,          32'd1,          32'hFFFF_FFFF,  32'd9,
        32'd10,         -32'sd10,       32'd99,         32'd100,
        32'h7FFF_FFFF,  32'h8000_0000,  32'h8000_0001,  32'd1000000000,
        -32'sd1000000000, 32'd999999999, 32'd12345,     -32'sd9,
        32'h5555_5555,  32'hAAAA_AAAA,  32'd2000000000, -32'sd1,
        32'h0000_FFFF,  32'hFFFF_0000
    };

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic signed [DATA_WIDTH-1:0] number = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [7:0]                   text_char;
    logic                         last_char;

    int   fail_count;
    int   pending;
    int   chars_checked;
    logic no_idle = 1'b0;
    int   stall_left = 0;
    int   numbers_sent = 0;
    int   negatives_sent = 0;
    int   zeros_sent = 0;

    int_to_decimal_ascii #(
        .DATA_WIDTH(DATA_WIDTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .number    (number),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .text_char (text_char),
        .last_char (last_char)
    );

    int_to_decimal_ascii_checker #(
        .DATA_WIDTH(DATA_WIDTH)
    ) text_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .number        (number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .text_char     (text_char),
        .last_char     (last_char),
        .fail_count    (fail_count),
        .pending       (pending),
        .chars_checked (chars_checked)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("int_to_decimal_ascii test failed");
        $finish;
    end

    // Output side: after each accepted character, insert a random stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                stall_left = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Present one number after a random gap and hold it until accepted
    task automatic send_number(input logic [31:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        number <= value;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        numbers_sent++;
        if (value[31])
        begin
            negatives_sent++;
        end
        if (value == 0)
        begin
            zeros_sent++;
        end
    endtask

    // Hold off the input until every expected character has come out
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [31:0] random_number();
        logic [31:0] v;
        logic [31:0] p;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                v = $urandom;
            end
            4, 5:
            begin
                v = 32'($urandom_range(0, 2000)) - 32'd1000;
            end
            6:
            begin
                // straddle a power of ten
                p = 32'd1;
                repeat ($urandom_range(0, 9)) p = p * 32'd10;
                v = p + 32'($urandom_range(0, 2)) - 32'd1;
                if ($urandom_range(0, 1))
                begin
                    v = -v;
                end
            end
            7:
            begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                begin
                    v = -v;
                end
            end
            8:
            begin
                case ($urandom_range(0, 4))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h8000_0001;
                    3: v = 32'hFFFF_FFFF;
                    default: v = 32'd0;
                endcase
            end
            default:
            begin
                v = 32'($urandom_range(0, 9));
                if ($urandom_range(0, 1))
                begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_EDGES; i++)
        begin
            send_number(EDGE_NUMBERS[i]);
        end
        wait_for_drain();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 50 == 0)
            begin
                no_idle <= ($urandom_range(0, 3) == 0);
            end
            if (i % 120 == 119)
            begin
                wait_for_drain();
            end
            send_number(random_number());
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        // give a stray character time to show up
        repeat (3 * LATENCY) @(posedge clk);

        $display("Covered %0d numbers (%0d negative, %0d zero) and %0d characters,",
                 numbers_sent, negatives_sent, zeros_sent, chars_checked);
        $display("with random input gaps and output stalls plus idle-free stretches.");
        if (fail_count == 0 && pending == 0)
        begin
            $display("int_to_decimal_ascii test passed");
        end
        else
        begin
            $display("int_to_decimal_ascii test failed");
        end
        $finish;
    end

endmodule
